// File: hw/rtl/sbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared constants and types for the stereo biquad low-pass block.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // fraction bits kept on the stored past outputs
  localparam int Y_FRAC_BITS = 8;

  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A1 = 3'd0,
    REG_COEF_A2 = 3'd1,
    REG_COEF_A3 = 3'd2,
    REG_COEF_B1 = 3'd3,
    REG_COEF_B2 = 3'd4
  } cfg_reg_t;

endpackage

// File: hw/rtl/sbq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_cfg
// Coefficient register file, shared by both channels.
// ----------------------------------------------------------------------------
module sbq_cfg
  import sbq_pkg::*;
#(
  parameter int COEF_W = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data,
  output logic signed [COEF_W-1:0] coef_a1,
  output logic signed [COEF_W-1:0] coef_a2,
  output logic signed [COEF_W-1:0] coef_a3,
  output logic signed [COEF_W-1:0] coef_b1,
  output logic signed [COEF_W-1:0] coef_b2
);

  // unity gain in Q2.x: only bit COEF_W-2 set
  localparam logic [COEF_W-1:0] UNITY = {2'b01, {(COEF_W-2){1'b0}}};

  logic [COEF_W-1:0] a1_r, a2_r, a3_r, b1_r, b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r <= UNITY;
      a2_r <= '0;
      a3_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_A1: a1_r <= cfg_data;
        REG_COEF_A2: a2_r <= cfg_data;
        REG_COEF_A3: a3_r <= cfg_data;
        REG_COEF_B1: b1_r <= cfg_data;
        REG_COEF_B2: b2_r <= cfg_data;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  assign coef_a1 = a1_r;
  assign coef_a2 = a2_r;
  assign coef_a3 = a3_r;
  assign coef_b1 = b1_r;
  assign coef_b2 = b2_r;

endmodule

// File: hw/rtl/sbq_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_chan
// One direct form I biquad channel: history registers, five parallel
// multipliers, exact accumulate, round and saturate, result register.
// ----------------------------------------------------------------------------
module sbq_chan
  import sbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  logic signed [SAMPLE_WIDTH-1:0]       x_in,
  input  logic signed [COEF_FRAC_BITS+1:0]     coef_a1,
  input  logic signed [COEF_FRAC_BITS+1:0]     coef_a2,
  input  logic signed [COEF_FRAC_BITS+1:0]     coef_a3,
  input  logic signed [COEF_FRAC_BITS+1:0]     coef_b1,
  input  logic signed [COEF_FRAC_BITS+1:0]     coef_b2,
  output logic signed [SAMPLE_WIDTH-1:0]       y_out
);

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int Y_W    = SAMPLE_WIDTH + Y_FRAC_BITS;
  localparam int PX_W   = COEF_W + SAMPLE_WIDTH;
  localparam int PY_W   = COEF_W + Y_W;
  // five terms of at most 2^(SW+CFB+8) each after alignment, plus headroom
  localparam int ACC_W  = SAMPLE_WIDTH + COEF_FRAC_BITS + 13;
  localparam int Y_SH   = COEF_FRAC_BITS;
  localparam int O_SH   = COEF_FRAC_BITS + Y_FRAC_BITS;

  localparam logic [ACC_W-1:0] Y_HALF = ACC_W'(1) << (Y_SH - 1);
  localparam logic [ACC_W-1:0] O_HALF = ACC_W'(1) << (O_SH - 1);

  logic signed [SAMPLE_WIDTH-1:0] x1_r, x2_r;
  logic signed [Y_W-1:0]          y1_r, y2_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic signed [PX_W-1:0]  p_a1, p_a2, p_a3;
  logic signed [PY_W-1:0]  p_b1, p_b2;
  logic signed [ACC_W-1:0] ff_sum, acc;
  logic signed [ACC_W-1:0] y_rnd, o_rnd, y_shr, o_shr;
  logic                    y_fits, o_fits;
  logic signed [Y_W-1:0]          y_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;

  assign p_a1 = coef_a1 * x_in;
  assign p_a2 = coef_a2 * x1_r;
  assign p_a3 = coef_a3 * x2_r;
  assign p_b1 = coef_b1 * y1_r;
  assign p_b2 = coef_b2 * y2_r;

  always_comb begin
    ff_sum = ACC_W'(p_a1) + ACC_W'(p_a2) + ACC_W'(p_a3);
    // feed-forward terms lifted to the feedback fraction position
    acc    = (ff_sum <<< Y_FRAC_BITS) - ACC_W'(p_b1) - ACC_W'(p_b2);
    y_rnd  = acc + Y_HALF;
    o_rnd  = acc + O_HALF;
    y_shr  = y_rnd >>> Y_SH;
    o_shr  = o_rnd >>> O_SH;

    y_fits = (&y_shr[ACC_W-1:Y_W-1]) || !(|y_shr[ACC_W-1:Y_W-1]);
    o_fits = (&o_shr[ACC_W-1:SAMPLE_WIDTH-1]) || !(|o_shr[ACC_W-1:SAMPLE_WIDTH-1]);

    if (y_fits) begin
      y_nxt = y_shr[Y_W-1:0];
    end else if (y_shr[ACC_W-1]) begin
      y_nxt = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(Y_W-1){1'b1}}};
    end

    if (o_fits) begin
      out_nxt = o_shr[SAMPLE_WIDTH-1:0];
    end else if (o_shr[ACC_W-1]) begin
      out_nxt = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_nxt = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (step) begin
      x2_r <= x1_r;
      x1_r <= x_in;
      y2_r <= y1_r;
      y1_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= out_nxt;
    end
  end

  assign y_out = out_r;

endmodule

// File: hw/rtl/stereo_biquad_lowpass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_biquad_lowpass
// Stereo direct form I biquad with shared, writable coefficients.
// ----------------------------------------------------------------------------
// Takes one stereo pair per clock and returns one filtered pair per clock
// while out_tready is held high; a stalled output holds the pair back. A beat
// is captured in an input register and filtered combinationally into the result
// register, so a result passes the input register and then the result register.
// The recurrence through the previous output
// (five multipliers in parallel, one accumulate, round and saturate) sets the
// clock period. Coefficients are signed Q2.COEF_FRAC_BITS and reset to a
// pass-through (a1 = 1.0, others 0); write them only while the block is idle.
// ----------------------------------------------------------------------------
module stereo_biquad_lowpass
  import sbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // left_in, right_in
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    out_tdata,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [COEF_FRAC_BITS+1:0]              cfg_data
);

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int DATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;

  logic                           in_valid_r, in_valid_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] left_r, right_r;
  logic                           advance, step, in_beat;
  logic signed [COEF_W-1:0]       a1, a2, a3, b1, b2;
  logic signed [SAMPLE_WIDTH-1:0] left_y, right_y;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_beat) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      left_r  <= in_tdata[SAMPLE_WIDTH-1:0];
      right_r <= in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  sbq_cfg #(
    .COEF_W (COEF_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef_a1   (a1),
    .coef_a2   (a2),
    .coef_a3   (a3),
    .coef_b1   (b1),
    .coef_b2   (b2)
  );

  sbq_chan #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .x_in    (left_r),
    .coef_a1 (a1),
    .coef_a2 (a2),
    .coef_a3 (a3),
    .coef_b1 (b1),
    .coef_b2 (b2),
    .y_out   (left_y)
  );

  sbq_chan #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .x_in    (right_r),
    .coef_a1 (a1),
    .coef_a2 (a2),
    .coef_a3 (a3),
    .coef_b1 (b1),
    .coef_b2 (b2),
    .y_out   (right_y)
  );

  assign out_tvalid = out_valid_r;
  // zero fill above the two samples
  assign out_tdata  = DATA_W'({right_y, left_y});

endmodule

// File: bench/biquad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_checker
// Watches the stereo biquad's stream and coefficient ports, runs its own
// fixed-point direct form I filter per channel and compares every result beat.
// ----------------------------------------------------------------------------
module biquad_checker
  import sbq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // left_in, right_in
  input  logic [31:0]          in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // left_out, right_out
  input  logic [31:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [17:0]          cfg_data,
  output int                   mismatches,
  output int                   pairs_checked,
  output int                   pairs_pending
);

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 16;
  localparam int HIST_W    = SAMPLE_W + Y_FRAC_BITS;
  localparam int LEFT      = 0;
  localparam int RIGHT     = 1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [HIST_W-1:0]   y1;
    logic signed [HIST_W-1:0]   y2;
  } section_hist_t;

  logic signed [FRAC_BITS+1:0] coef [NUM_COEFS];
  section_hist_t               hist [2];
  logic [31:0]                 filtered_q [$];
  logic [31:0]                 want;

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one direct form I step on a channel; advances that channel's history
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(int ch,
      logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint y_hist;
    longint y_out;
    acc = (longint'(coef[REG_COEF_A1]) * longint'(x)
         + longint'(coef[REG_COEF_A2]) * longint'(hist[ch].x1)
         + longint'(coef[REG_COEF_A3]) * longint'(hist[ch].x2)) * 256
        - longint'(coef[REG_COEF_B1]) * longint'(hist[ch].y1)
        - longint'(coef[REG_COEF_B2]) * longint'(hist[ch].y2);
    // add half then floor: ties go toward +inf
    y_hist = clamp((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS, HIST_W);
    y_out  = clamp((acc + (longint'(1) <<< (FRAC_BITS + Y_FRAC_BITS - 1)))
                   >>> (FRAC_BITS + Y_FRAC_BITS), SAMPLE_W);
    hist[ch].x2 = hist[ch].x1;
    hist[ch].x1 = x;
    hist[ch].y2 = hist[ch].y1;
    hist[ch].y1 = y_hist[HIST_W-1:0];
    return y_out[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("[%0t] %s mismatch: got %0d expected %0d", $time, what, got, exp_val);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coef[REG_COEF_A1] = 18'sd65536;
      coef[REG_COEF_A2] = '0;
      coef[REG_COEF_A3] = '0;
      coef[REG_COEF_B1] = '0;
      coef[REG_COEF_B2] = '0;
      for (int c = 0; c < 2; c++) begin
        hist[c] = '{x1: '0, x2: '0, y1: '0, y2: '0};
      end
      filtered_q.delete();
      mismatches = 0;
      pairs_checked <= 0;
      pairs_pending <= 0;
    end else begin
      // writes above the register map are dropped
      if (cfg_we && cfg_index < NUM_COEFS)
        coef[cfg_index] = $signed(cfg_data);

      if (out_tvalid && out_tready) begin
        pairs_checked <= pairs_checked + 1;
        if (filtered_q.size() == 0) begin
          report_mismatch("unexpected beat, left", $signed(out_tdata[15:0]), 0);
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata[15:0] !== want[15:0])
            report_mismatch("left_out", $signed(out_tdata[15:0]), $signed(want[15:0]));
          if (out_tdata[31:16] !== want[31:16])
            report_mismatch("right_out", $signed(out_tdata[31:16]),
                            $signed(want[31:16]));
        end
      end

      if (in_tvalid && in_tready) begin
        want[15:0]  = filter_sample(LEFT, in_tdata[15:0]);
        want[31:16] = filter_sample(RIGHT, in_tdata[31:16]);
        filtered_q.push_back(want);
      end

      pairs_pending <= filtered_q.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the stereo biquad: directed corner pairs, then random pairs
// over many coefficient loads and handshake pressure mixes, checked beat by
// beat by biquad_checker.
// ----------------------------------------------------------------------------
module testbench
  import sbq_pkg::*;
();

  localparam int   LIMIT    = 500000;
  localparam int   PHASES   = 12;
  localparam int   PER_PHASE = 104;
  localparam logic signed [17:0] COEF_MAX = 18'sd131071;
  localparam logic signed [17:0] COEF_MIN = -18'sd131072;
  localparam logic signed [17:0] COEF_ONE = 18'sd65536;
  localparam logic signed [17:0] COEF_HALF = 18'sd32768;
  localparam logic signed [15:0] CORNER_VALS [4] = '{32767, -32768, 0, -1};

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [17:0]          cfg_data   = '0;

  int mismatches;
  int pairs_checked;
  int pairs_pending;
  int pairs_sent = 0;
  int loads      = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int cycles     = 0;

  always #5 clk = ~clk;

  stereo_biquad_lowpass uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  biquad_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pairs_checked (pairs_checked),
    .pairs_pending (pairs_pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d pairs back",
               cycles, pairs_checked, pairs_sent);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pair(logic signed [15:0] left, logic signed [15:0] right);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pairs_sent = pairs_sent + 1;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pairs_checked != pairs_sent) @(posedge clk);
  endtask

  // coefficients only change with the pipe empty
  task automatic load_coefs(logic signed [17:0] a1, logic signed [17:0] a2,
                            logic signed [17:0] a3, logic signed [17:0] b1,
                            logic signed [17:0] b2);
    logic signed [17:0] vals [NUM_COEFS];
    vals = '{a1, a2, a3, b1, b2};
    drain();
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    // a stray write above the register map must change nothing
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(NUM_COEFS + $urandom_range(0, 2));
    cfg_data  <= 18'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    loads = loads + 1;
  endtask

  function automatic logic signed [15:0] pick_sample();
    if ($urandom_range(7) == 0) return CORNER_VALS[$urandom_range(3)];
    return 16'($urandom);
  endfunction

  task automatic set_pressure(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 52; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 52; end
      default: begin idle_pct = 21; stall_pct <= 21; end
    endcase
  endtask

  initial begin
    int b2_val;
    int a_val;
    logic signed [17:0] pick [5];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through after reset
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sh5555, 16'shaaaa);
    send_pair(16'shaaaa, 16'sh5555);

    // runaway positive feedback: history and outputs pin at the rails
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
    repeat (4) send_pair(16'sd32767, -16'sd32768);
    repeat (3) send_pair(-16'sd32768, 16'sd32767);

    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
    repeat (4) send_pair(-16'sd32768, 16'sd32767);
    repeat (3) send_pair(16'sd32767, -16'sd1);

    // half gain: odd inputs land exactly on a rounding tie
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    send_pair(16'sd1, -16'sd1);
    send_pair(16'sd3, -16'sd3);
    send_pair(-16'sd32768, 16'sd32767);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: load_coefs(COEF_ONE, '0, '0, '0, '0);
        1: begin
          // stable low-pass: b2 < 1 and |b1| < 1 + b2
          b2_val = $urandom_range(0, 62000);
          a_val  = $urandom_range(0, 12000);
          load_coefs(18'(a_val), 18'(2 * a_val), 18'(a_val),
                     18'(-int'($urandom_range(0, 65536 + b2_val - 3000))), 18'(b2_val));
        end
        2: load_coefs(18'($urandom), 18'($urandom), 18'($urandom),
                      18'($urandom), 18'($urandom));
        default: begin
          for (int k = 0; k < 5; k++) begin
            case ($urandom_range(2))
              0: pick[k] = COEF_MAX;
              1: pick[k] = COEF_MIN;
              default: pick[k] = '0;
            endcase
          end
          load_coefs(pick[0], pick[1], pick[2], pick[3], pick[4]);
        end
      endcase
      set_pressure((p / 3) % 4);
      for (int n = 0; n < PER_PHASE; n++) begin
        send_pair(pick_sample(), pick_sample());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d sample pairs checked over %0d coefficient loads", pairs_checked, loads);
    $display("pass-through, stable low-pass, random and railed coefficients, four pressure mixes");
    if (pairs_pending != 0)
      $display("%0d expected pairs never came out", pairs_pending);
    if (mismatches == 0 && pairs_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
